@@ rtl/tf_pkg.sv @@
// Shared types, constants and Twofish table functions.
`default_nettype none
package tf_pkg;

	localparam int ROUNDS_DEF  = 16;
	localparam int SBOX_DEPTH  = 256;
	localparam int WORD_W      = 32;
	localparam int DATA_W      = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int KSZ_W       = 2;
	localparam int MODE_W      = 2;
	localparam int VB_W        = 5;
	localparam int BLK_BYTES   = 16;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_A    = 3'd0,
		REG_KEY_B    = 3'd1,
		REG_KEY_C    = 3'd2,
		REG_KEY_D    = 3'd3,
		REG_KEY_SIZE = 3'd4,
		REG_MODE     = 3'd5,
		REG_IV_LOW   = 3'd6,
		REG_IV_HIGH  = 3'd7
	} cfg_reg_t;

	localparam logic [KSZ_W-1:0] KSZ_128 = 2'd0;
	localparam logic [KSZ_W-1:0] KSZ_192 = 2'd1;

	// which key words feed the h unit
	typedef enum logic [1:0] {
		LSEL_ME = 2'd0,
		LSEL_MO = 2'd1,
		LSEL_SV = 2'd2
	} lsel_t;

	typedef struct packed {
		logic [7:0] x;
		lsel_t      lsel;
	} hctl_t;

	typedef logic [3:0][WORD_W-1:0] blk_t;

	localparam logic [3:0] QT [2][4][16] = '{
		'{'{4'd8,4'd1,4'd7,4'd13,4'd6,4'd15,4'd3,4'd2,4'd0,4'd11,4'd5,4'd9,4'd14,4'd12,4'd10,4'd4},
		  '{4'd14,4'd12,4'd11,4'd8,4'd1,4'd2,4'd3,4'd5,4'd15,4'd4,4'd10,4'd6,4'd7,4'd0,4'd9,4'd13},
		  '{4'd11,4'd10,4'd5,4'd14,4'd6,4'd13,4'd9,4'd0,4'd12,4'd8,4'd15,4'd3,4'd2,4'd4,4'd7,4'd1},
		  '{4'd13,4'd7,4'd15,4'd4,4'd1,4'd2,4'd6,4'd14,4'd9,4'd11,4'd3,4'd0,4'd8,4'd5,4'd12,4'd10}},
		'{'{4'd2,4'd8,4'd11,4'd13,4'd15,4'd7,4'd6,4'd14,4'd3,4'd1,4'd9,4'd4,4'd0,4'd10,4'd12,4'd5},
		  '{4'd1,4'd14,4'd2,4'd11,4'd4,4'd12,4'd3,4'd7,4'd6,4'd13,4'd10,4'd5,4'd15,4'd9,4'd0,4'd8},
		  '{4'd4,4'd12,4'd7,4'd5,4'd1,4'd6,4'd9,4'd10,4'd0,4'd14,4'd13,4'd8,4'd2,4'd11,4'd3,4'd15},
		  '{4'd11,4'd9,4'd5,4'd1,4'd12,4'd3,4'd13,4'd14,4'd6,4'd4,4'd7,4'd15,4'd2,4'd0,4'd8,4'd10}}
	};

	localparam logic [7:0] MDS_M [4][4] = '{
		'{8'h01,8'hEF,8'h5B,8'h5B}, '{8'h5B,8'hEF,8'hEF,8'h01},
		'{8'hEF,8'h5B,8'h01,8'hEF}, '{8'hEF,8'h01,8'hEF,8'h5B}
	};

	localparam logic [7:0] RS_M [4][8] = '{
		'{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
		'{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
		'{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
		'{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}
	};

	localparam logic [8:0] POLY_MDS = 9'h169;
	localparam logic [8:0] POLY_RS  = 9'h14D;

	// GF(2^8) multiply, shift-and-add
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
			input logic [8:0] poly);
		logic [7:0] acc;
		logic [8:0] x;
		acc = '0;
		x = {1'b0, a};
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8]) x = x ^ poly;
		end
		return acc;
	endfunction

	// fixed byte permutation q0 / q1
	function automatic logic [7:0] qperm(input logic which, input logic [7:0] x);
		logic [3:0] a, b, na, nb;
		a = x[7:4];
		b = x[3:0];
		for (int r = 0; r < 2; r++) begin
			na = a ^ b;
			nb = a ^ {b[0], b[3:1]} ^ {a[0], 3'b000};
			a = QT[which][2*r][na];
			b = QT[which][2*r+1][nb];
		end
		return {b, a};
	endfunction

	// h function byte stage, result bytes y0 in the low bits
	function automatic logic [31:0] h_func(input logic [7:0] x, input logic [31:0] l0,
			input logic [31:0] l1, input logic [31:0] l2, input logic [31:0] l3,
			input logic [2:0] k);
		logic [7:0] y0, y1, y2, y3;
		y0 = x; y1 = x; y2 = x; y3 = x;
		if (k == 3'd4) begin
			y0 = qperm(1'b1, y0) ^ l3[7:0];
			y1 = qperm(1'b0, y1) ^ l3[15:8];
			y2 = qperm(1'b0, y2) ^ l3[23:16];
			y3 = qperm(1'b1, y3) ^ l3[31:24];
		end
		if (k >= 3'd3) begin
			y0 = qperm(1'b1, y0) ^ l2[7:0];
			y1 = qperm(1'b1, y1) ^ l2[15:8];
			y2 = qperm(1'b0, y2) ^ l2[23:16];
			y3 = qperm(1'b0, y3) ^ l2[31:24];
		end
		y0 = qperm(1'b1, qperm(1'b0, qperm(1'b0, y0) ^ l1[7:0]) ^ l0[7:0]);
		y1 = qperm(1'b0, qperm(1'b0, qperm(1'b1, y1) ^ l1[15:8]) ^ l0[15:8]);
		y2 = qperm(1'b1, qperm(1'b1, qperm(1'b0, y2) ^ l1[23:16]) ^ l0[23:16]);
		y3 = qperm(1'b0, qperm(1'b1, qperm(1'b1, y3) ^ l1[31:24]) ^ l0[31:24]);
		return {y3, y2, y1, y0};
	endfunction

	// one MDS column times a byte
	function automatic logic [31:0] mds_col(input logic [1:0] j, input logic [7:0] v);
		logic [31:0] w;
		for (int i = 0; i < 4; i++)
			w[8*i +: 8] = gf_mul(MDS_M[i][j], v, POLY_MDS);
		return w;
	endfunction

	// RS code over eight key bytes
	function automatic logic [31:0] rs_word(input logic [63:0] kw);
		logic [31:0] s;
		logic [7:0] acc;
		for (int r = 0; r < 4; r++) begin
			acc = '0;
			for (int j = 0; j < 8; j++)
				acc = acc ^ gf_mul(RS_M[r][j], kw[8*j +: 8], POLY_RS);
			s[8*r +: 8] = acc;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

@@ rtl/tf_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module tf_ram #(
	parameter int W = 32,
	parameter int D = 256
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr_a,
	input  wire logic [$clog2(D)-1:0] raddr_b,
	output      logic [W-1:0]         rdata_a,
	output      logic [W-1:0]         rdata_b
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

@@ rtl/tf_hunit.sv @@
// Shared key-schedule h unit: q layers and MDS columns for one byte.
`default_nettype none
module tf_hunit import tf_pkg::*; (
	input  wire hctl_t             ctl,
	input  wire logic [DATA_W-1:0] key_a,
	input  wire logic [DATA_W-1:0] key_b,
	input  wire logic [DATA_W-1:0] key_c,
	input  wire logic [DATA_W-1:0] key_d,
	input  wire logic [KSZ_W-1:0]  key_size,
	output      blk_t              cols,
	output      logic [WORD_W-1:0] hword
);

	logic [2:0]        k;
	logic [WORD_W-1:0] rs0, rs1, rs2, rs3;
	logic [WORD_W-1:0] l0, l1, l2, l3;
	logic [WORD_W-1:0] y;

	assign k = (key_size == KSZ_128) ? 3'd2 : (key_size == KSZ_192) ? 3'd3 : 3'd4;

	assign rs0 = rs_word(key_a);
	assign rs1 = rs_word(key_b);
	assign rs2 = rs_word(key_c);
	assign rs3 = rs_word(key_d);

	// key word selection; S-box words run in reverse order
	always_comb begin
		l0 = '0; l1 = '0; l2 = '0; l3 = '0;
		case (ctl.lsel)
			LSEL_ME: begin
				l0 = key_a[31:0]; l1 = key_b[31:0]; l2 = key_c[31:0]; l3 = key_d[31:0];
			end
			LSEL_MO: begin
				l0 = key_a[63:32]; l1 = key_b[63:32]; l2 = key_c[63:32]; l3 = key_d[63:32];
			end
			LSEL_SV: begin
				if (k == 3'd2) begin
					l0 = rs1; l1 = rs0;
				end else if (k == 3'd3) begin
					l0 = rs2; l1 = rs1; l2 = rs0;
				end else begin
					l0 = rs3; l1 = rs2; l2 = rs1; l3 = rs0;
				end
			end
			default: begin
				l0 = '0;
			end
		endcase
	end

	assign y = h_func(ctl.x, l0, l1, l2, l3, k);

	always_comb begin
		for (int j = 0; j < 4; j++)
			cols[j] = mds_col(2'(j), y[8*j +: 8]);
		hword = cols[0] ^ cols[1] ^ cols[2] ^ cols[3];
	end

endmodule
`default_nettype wire

@@ rtl/tf_round.sv @@
// One Twofish round (F function adds and the rotate/xor mix), either direction.
`default_nettype none
module tf_round import tf_pkg::*; (
	input  wire blk_t              blk,
	input  wire blk_t              ga,
	input  wire blk_t              gb,
	input  wire logic [DATA_W-1:0] rk,
	input  wire logic              dec,
	output      blk_t              nxt
);

	logic [WORD_W-1:0] g0, g1, t0, t1, n2, n3, x2, x3;

	assign g0 = ga[0] ^ ga[1] ^ ga[2] ^ ga[3];
	assign g1 = gb[0] ^ gb[1] ^ gb[2] ^ gb[3];

	// PHT plus round subkeys
	assign t0 = g0 + g1 + rk[31:0];
	assign t1 = g0 + {g1[30:0], 1'b0} + rk[63:32];

	assign x2 = blk[2] ^ t0;
	assign x3 = blk[3] ^ t1;

	always_comb begin
		if (!dec) begin
			n2 = {x2[0], x2[31:1]};
			n3 = {blk[3][30:0], blk[3][31]} ^ t1;
		end else begin
			n2 = {blk[2][30:0], blk[2][31]} ^ t0;
			n3 = {x3[0], x3[31:1]};
		end
		nxt[0] = n2;
		nxt[1] = n3;
		nxt[2] = blk[0];
		nxt[3] = blk[1];
	end

endmodule
`default_nettype wire

@@ rtl/twofish_block_cipher_top.sv @@
// Twofish ECB/CBC block cipher top level: sequencer, key store and block datapath.
// Sequence: accept, input whitening (request, apply), then per round an S-box and
// subkey read and the round update, then output whitening; after reset or a key change
// the first item is preceded by key setup (256 S-box entries, then the subkey pairs).
// Items are taken one at a time (in_ready only in idle); the registered S-box RAM reads set the pace.
// Reset clears control, chaining value and config; key stores rebuild before use.
`default_nettype none
module twofish_block_cipher_top import tf_pkg::*; #(
	parameter int ROUNDS = ROUNDS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic [DATA_W-1:0]    data_low,
	input  wire logic [DATA_W-1:0]    data_high,
	input  wire logic [VB_W-1:0]      valid_bytes,
	input  wire logic                 first_block,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic [DATA_W-1:0]    out_low,
	output      logic [DATA_W-1:0]    out_high
);

	localparam int RK_PAIRS = ROUNDS + 4;
	localparam int RK_AW    = $clog2(RK_PAIRS);
	localparam int RND_W    = $clog2(ROUNDS);
	localparam int SB_AW    = $clog2(SBOX_DEPTH);
	localparam int CNT_W    = SB_AW;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_KSBOX  = 9'b000000010,
		S_KRK    = 9'b000000100,
		S_WREQ   = 9'b000001000,
		S_WAPPLY = 9'b000010000,
		S_RREQ   = 9'b000100000,
		S_RCALC  = 9'b001000000,
		S_OREQ   = 9'b010000000,
		S_OFIN   = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [DATA_W-1:0] key_a_q, key_b_q, key_c_q, key_d_q, iv_lo_q, iv_hi_q;
	logic [KSZ_W-1:0]  key_size_q;
	logic [MODE_W-1:0] mode_q;
	logic              stale_q;
	logic              cbc, dec;

	assign cbc = mode_q[0];
	assign dec = mode_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q    <= '0;
			key_b_q    <= '0;
			key_c_q    <= '0;
			key_d_q    <= '0;
			key_size_q <= '0;
			mode_q     <= '0;
			iv_lo_q    <= '0;
			iv_hi_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_A:    key_a_q    <= cfg_data;
				REG_KEY_B:    key_b_q    <= cfg_data;
				REG_KEY_C:    key_c_q    <= cfg_data;
				REG_KEY_D:    key_d_q    <= cfg_data;
				REG_KEY_SIZE: key_size_q <= cfg_data[KSZ_W-1:0];
				REG_MODE:     mode_q     <= cfg_data[MODE_W-1:0];
				REG_IV_LOW:   iv_lo_q    <= cfg_data;
				REG_IV_HIGH:  iv_hi_q    <= cfg_data;
				default:      mode_q     <= mode_q;
			endcase
		end
	end

	// shared h unit
	hctl_t             hctl;
	blk_t              hcols;
	logic [WORD_W-1:0] hword;
	logic [CNT_W-1:0]  cnt_q;

	assign hctl.x    = cnt_q;
	assign hctl.lsel = (state_q == S_KSBOX) ? LSEL_SV : (cnt_q[0] ? LSEL_MO : LSEL_ME);

	tf_hunit u_hunit (
		.ctl      (hctl),
		.key_a    (key_a_q),
		.key_b    (key_b_q),
		.key_c    (key_c_q),
		.key_d    (key_d_q),
		.key_size (key_size_q),
		.cols     (hcols),
		.hword    (hword)
	);

	// subkey pair from the two h results
	logic [WORD_W-1:0] rka_q, rkb, rk0, rk1s;
	assign rkb  = {hword[23:0], hword[31:24]};
	assign rk0  = rka_q + rkb;
	assign rk1s = rka_q + {rkb[30:0], 1'b0};

	// block datapath registers
	blk_t              blk_q;
	logic [DATA_W-1:0] pad_lo_q, pad_hi_q, chain_lo_q, chain_hi_q;
	logic [RND_W-1:0]  rnd_q;
	logic [RND_W-1:0]  ridx;

	assign ridx = dec ? RND_W'(ROUNDS - 1) - rnd_q : rnd_q;

	// subkey store
	logic              rk_we;
	logic [RK_AW-1:0]  rk_addr_a, rk_addr_b;
	logic [DATA_W-1:0] rk_da, rk_db;

	assign rk_we = (state_q == S_KRK) && cnt_q[0];

	always_comb begin
		rk_addr_a = RK_AW'(dec ? 2 : 0);
		rk_addr_b = RK_AW'(dec ? 3 : 1);
		if (state_q == S_RREQ || state_q == S_RCALC) begin
			rk_addr_a = RK_AW'(ridx) + RK_AW'(4);
		end else if (state_q == S_OREQ || state_q == S_OFIN) begin
			rk_addr_a = RK_AW'(dec ? 0 : 2);
			rk_addr_b = RK_AW'(dec ? 1 : 3);
		end
	end

	tf_ram #(.W(DATA_W), .D(RK_PAIRS)) u_rk_ram (
		.clk     (clk),
		.we      (rk_we),
		.waddr   (cnt_q[RK_AW:1]),
		.wdata   ({rk1s[22:0], rk1s[31:23], rk0}),
		.raddr_a (rk_addr_a),
		.raddr_b (rk_addr_b),
		.rdata_a (rk_da),
		.rdata_b (rk_db)
	);

	// key-dependent S-box/MDS columns, one RAM per byte lane
	blk_t              ga, gb;
	logic [WORD_W-1:0] b1r;
	assign b1r = {blk_q[1][23:0], blk_q[1][31:24]};

	for (genvar j = 0; j < 4; j++) begin : g_sbox
		tf_ram #(.W(WORD_W), .D(SBOX_DEPTH)) u_sb_ram (
			.clk     (clk),
			.we      (state_q == S_KSBOX),
			.waddr   (cnt_q[SB_AW-1:0]),
			.wdata   (hcols[j]),
			.raddr_a (blk_q[0][8*j +: 8]),
			.raddr_b (b1r[8*j +: 8]),
			.rdata_a (ga[j]),
			.rdata_b (gb[j])
		);
	end

	blk_t rnd_nxt;

	tf_round u_round (
		.blk (blk_q),
		.ga  (ga),
		.gb  (gb),
		.rk  (rk_da),
		.dec (dec),
		.nxt (rnd_nxt)
	);

	// zero padding of the incoming block
	logic [DATA_W-1:0] pad_lo, pad_hi, chs_lo, chs_hi, enc_lo, enc_hi;
	always_comb begin
		for (int m = 0; m < BLK_BYTES / 2; m++) begin
			pad_lo[8*m +: 8] = (valid_bytes > VB_W'(m)) ? data_low[8*m +: 8] : 8'h00;
			pad_hi[8*m +: 8] = (valid_bytes > VB_W'(m + 8)) ? data_high[8*m +: 8] : 8'h00;
		end
	end
	assign chs_lo = first_block ? iv_lo_q : chain_lo_q;
	assign chs_hi = first_block ? iv_hi_q : chain_hi_q;
	assign enc_lo = (cbc && !dec) ? pad_lo ^ chs_lo : pad_lo;
	assign enc_hi = (cbc && !dec) ? pad_hi ^ chs_hi : pad_hi;

	// final swap and output whitening
	logic [DATA_W-1:0] res_lo, res_hi;
	assign res_lo = {blk_q[3] ^ rk_da[63:32], blk_q[2] ^ rk_da[31:0]};
	assign res_hi = {blk_q[1] ^ rk_db[63:32], blk_q[0] ^ rk_db[31:0]};

	logic accept, out_free, key_wr, ks_done;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign key_wr   = cfg_we && (cfg_index == REG_KEY_A || cfg_index == REG_KEY_B ||
			cfg_index == REG_KEY_C || cfg_index == REG_KEY_D ||
			cfg_index == REG_KEY_SIZE);
	assign ks_done  = (state_q == S_KRK) && (cnt_q == CNT_W'(2 * RK_PAIRS - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			stale_q    <= 1'b1;
			cnt_q      <= '0;
			rnd_q      <= '0;
			out_valid  <= 1'b0;
			chain_lo_q <= '0;
			chain_hi_q <= '0;
		end else begin
			// result held until taken, set when the last stage finishes
			out_valid <= (out_valid && !out_ready) || (state_q == S_OFIN && out_free);
			stale_q   <= key_wr || (stale_q && !ks_done);
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (cbc && first_block) begin
							chain_lo_q <= iv_lo_q;
							chain_hi_q <= iv_hi_q;
						end
						state_q <= stale_q ? S_KSBOX : S_WREQ;
					end
				end
				S_KSBOX: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SBOX_DEPTH - 1)) state_q <= S_KRK;
				end
				S_KRK: begin
					cnt_q <= cnt_q + 1'b1;
					if (ks_done) state_q <= S_WREQ;
				end
				S_WREQ: state_q <= S_WAPPLY;
				S_WAPPLY: begin
					rnd_q   <= '0;
					state_q <= S_RREQ;
				end
				S_RREQ: state_q <= S_RCALC;
				S_RCALC: begin
					rnd_q <= rnd_q + 1'b1;
					state_q <= (rnd_q == RND_W'(ROUNDS - 1)) ? S_OREQ : S_RREQ;
				end
				S_OREQ: state_q <= S_OFIN;
				S_OFIN: begin
					if (out_free) begin
						if (cbc) begin
							chain_lo_q <= dec ? pad_lo_q : res_lo;
							chain_hi_q <= dec ? pad_hi_q : res_hi;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_KRK && !cnt_q[0]) rka_q <= hword;
		if (accept) begin
			pad_lo_q <= pad_lo;
			pad_hi_q <= pad_hi;
			blk_q    <= {enc_hi[63:32], enc_hi[31:0], enc_lo[63:32], enc_lo[31:0]};
		end
		if (state_q == S_WAPPLY) begin
			blk_q[0] <= blk_q[0] ^ rk_da[31:0];
			blk_q[1] <= blk_q[1] ^ rk_da[63:32];
			blk_q[2] <= blk_q[2] ^ rk_db[31:0];
			blk_q[3] <= blk_q[3] ^ rk_db[63:32];
		end
		if (state_q == S_RCALC) blk_q <= rnd_nxt;
		if (state_q == S_OFIN && out_free) begin
			out_low  <= (cbc && dec) ? res_lo ^ chain_lo_q : res_lo;
			out_high <= (cbc && dec) ? res_hi ^ chain_hi_q : res_hi;
		end
	end

endmodule
`default_nettype wire

@@ test/twofish_block_cipher_top_tb.sv @@
// Testbench for the Twofish ECB/CBC block cipher: directed table, random blocks, self-check.
`timescale 1ns / 100ps
module twofish_block_cipher_top_tb;
	import tf_pkg::*;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
	} blk128_t;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  nbytes;
		logic        restart;
		bit          typed;
		logic [63:0] want_lo;
		logic [63:0] want_hi;
	} vec_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;

	// q permutation nibble tables, entry 0 in the top nibble
	localparam logic [63:0] QTAB [0:1][0:3] = '{
		'{64'h817D6F320B59ECA4, 64'hECB81235F4A6709D,
		  64'hBA5E6D90C8F32471, 64'hD7F4126E9B3085CA},
		'{64'h28BDF76E31940AC5, 64'h1E2B4C376DA5F908,
		  64'h4C75169A0ED82B3F, 64'hB951C3DE647F208A}
	};
	// MDS rows, column 0 in the top byte
	localparam logic [31:0] MDS_ROW [0:3] = '{
		32'h01EF5B5B, 32'h5BEFEF01, 32'hEF5B01EF, 32'hEF01EF5B
	};
	// RS rows, column 0 in the top byte
	localparam logic [63:0] RS_ROW [0:3] = '{
		64'h01A455875A58DB9E, 64'hA45682F31EC668E5,
		64'h02A1FCC147AE3D19, 64'hA455875A58DB9E03
	};
	// q0/q1 choice per byte for each h stage, bit j for byte j
	localparam logic [3:0] HSTAGE [0:4] = '{4'b0101, 4'b1100, 4'b1010, 4'b0011, 4'b1001};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [DATA_W-1:0]    data_low = '0;
	logic [DATA_W-1:0]    data_high = '0;
	logic [VB_W-1:0]      valid_bytes = '0;
	logic                 first_block = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DATA_W-1:0]    out_low;
	logic [DATA_W-1:0]    out_high;

	twofish_block_cipher_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_low(data_low), .data_high(data_high),
		.valid_bytes(valid_bytes), .first_block(first_block),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_low(out_low), .out_high(out_high)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cipher model state
	logic [63:0] key_w [0:3];
	logic [1:0]  key_len;
	logic [1:0]  mode;
	logic [63:0] iv_lo, iv_hi, chain_lo, chain_hi;
	logic [31:0] subkey [0:39];
	logic [31:0] sbox_tab [0:1023];
	bit          keys_dirty;

	blk128_t     pending_blocks[$];
	int          fail_count = 0;
	bit          quiet = 0;
	bit          hold_req = 0;

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b,
			input logic [8:0] poly);
		logic [8:0] acc;
		acc = '0;
		for (int i = 7; i >= 0; i--) begin
			acc = {acc[7:0], 1'b0};
			if (acc[8]) acc = acc ^ poly;
			if (a[i]) acc = acc ^ {1'b0, b};
		end
		return acc[7:0];
	endfunction

	function automatic logic [7:0] qmap(input int w, input logic [7:0] x);
		logic [3:0] a, b, na, nb;
		a = x[7:4];
		b = x[3:0];
		for (int r = 0; r < 2; r++) begin
			na = a ^ b;
			nb = a ^ {b[0], b[3:1]} ^ {a[0], 3'b000};
			a = QTAB[w][2*r][63-4*na -: 4];
			b = QTAB[w][2*r+1][63-4*nb -: 4];
		end
		return {b, a};
	endfunction

	// h byte stage over k key words, byte j in bits 8j+7..8j
	function automatic logic [31:0] hbytes(input logic [7:0] x, input logic [31:0] lw [0:3],
			input int k);
		logic [31:0] y;
		y = {4{x}};
		for (int s = k; s >= 0; s--) begin
			for (int j = 0; j < 4; j++)
				y[8*j +: 8] = qmap(HSTAGE[s][j], y[8*j +: 8]);
			if (s > 0) y = y ^ lw[s-1];
		end
		return y;
	endfunction

	function automatic logic [31:0] mds_column(input int j, input logic [7:0] v);
		logic [31:0] w;
		for (int i = 0; i < 4; i++)
			w[8*i +: 8] = gmul(MDS_ROW[i][31-8*j -: 8], v, 9'h169);
		return w;
	endfunction

	function automatic logic [31:0] hword(input logic [7:0] x, input logic [31:0] lw [0:3],
			input int k);
		logic [31:0] y, acc;
		y = hbytes(x, lw, k);
		acc = '0;
		for (int j = 0; j < 4; j++) acc = acc ^ mds_column(j, y[8*j +: 8]);
		return acc;
	endfunction

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// subkeys and key-dependent S-box table from the key registers
	task automatic expand_key();
		logic [31:0] even_w [0:3];
		logic [31:0] odd_w [0:3];
		logic [31:0] sw [0:3];
		logic [31:0] a, b, y;
		logic [7:0]  acc;
		int          k;
		k = (key_len == KSZ_128) ? 2 : (key_len == KSZ_192) ? 3 : 4;
		for (int i = 0; i < 4; i++) begin
			even_w[i] = '0; odd_w[i] = '0; sw[i] = '0;
		end
		for (int i = 0; i < k; i++) begin
			even_w[i] = key_w[i][31:0];
			odd_w[i] = key_w[i][63:32];
			for (int r = 0; r < 4; r++) begin
				acc = '0;
				for (int j = 0; j < 8; j++)
					acc = acc ^ gmul(RS_ROW[r][63-8*j -: 8], key_w[i][8*j +: 8], 9'h14D);
				sw[k-1-i][8*r +: 8] = acc;
			end
		end
		for (int i = 0; i < 20; i++) begin
			a = hword(8'(2*i), even_w, k);
			b = rol(hword(8'(2*i+1), odd_w, k), 8);
			subkey[2*i] = a + b;
			subkey[2*i+1] = rol(a + 2*b, 9);
		end
		for (int i = 0; i < 256; i++) begin
			y = hbytes(8'(i), sw, k);
			for (int j = 0; j < 4; j++) sbox_tab[j*256+i] = mds_column(j, y[8*j +: 8]);
		end
		keys_dirty = 0;
	endtask

	function automatic logic [31:0] gsub(input logic [31:0] x);
		return sbox_tab[x[7:0]] ^ sbox_tab[256+x[15:8]] ^ sbox_tab[512+x[23:16]]
			^ sbox_tab[768+x[31:24]];
	endfunction

	function automatic blk128_t run_rounds(input blk128_t din, input bit dec);
		logic [31:0] w [0:3];
		logic [31:0] r0, r1, t0, t1;
		blk128_t     dout;
		int          idx;
		w[0] = din.lo[31:0]; w[1] = din.lo[63:32]; w[2] = din.hi[31:0]; w[3] = din.hi[63:32];
		for (int i = 0; i < 4; i++) w[i] = w[i] ^ subkey[(dec ? 4 : 0) + i];
		for (int n = 0; n < 16; n++) begin
			idx = dec ? 15 - n : n;
			r0 = w[0]; r1 = w[1];
			t0 = gsub(w[0]);
			t1 = gsub(rol(w[1], 8));
			t0 = t0 + t1;
			t1 = t1 + t0;
			t0 = t0 + subkey[2*idx+8];
			t1 = t1 + subkey[2*idx+9];
			if (!dec) begin
				w[2] = rol(w[2] ^ t0, 31);
				w[3] = rol(w[3], 1) ^ t1;
			end else begin
				w[2] = rol(w[2], 1) ^ t0;
				w[3] = rol(w[3] ^ t1, 31);
			end
			w[0] = w[2]; w[1] = w[3]; w[2] = r0; w[3] = r1;
		end
		// undo the last swap, then output whitening
		r0 = w[0]; r1 = w[1]; w[0] = w[2]; w[1] = w[3]; w[2] = r0; w[3] = r1;
		for (int i = 0; i < 4; i++) w[i] = w[i] ^ subkey[(dec ? 0 : 4) + i];
		dout.lo = {w[1], w[0]};
		dout.hi = {w[3], w[2]};
		return dout;
	endfunction

	// expected output for one accepted block, chaining state updated
	task automatic predict_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] nb, input logic restart, output blk128_t res);
		int      n;
		bit      cbc, dec;
		blk128_t pt;
		n = (nb > 16) ? 16 : nb;
		cbc = mode[0];
		dec = mode[1];
		if (n < 8) begin
			lo = lo & ((64'd1 << (8*n)) - 64'd1);
			hi = '0;
		end else if (n < 16) begin
			hi = hi & ((64'd1 << (8*(n-8))) - 64'd1);
		end
		if (keys_dirty) expand_key();
		if (cbc && restart) begin
			chain_lo = iv_lo; chain_hi = iv_hi;
		end
		pt.lo = lo; pt.hi = hi;
		if (cbc && !dec) begin
			pt.lo = pt.lo ^ chain_lo; pt.hi = pt.hi ^ chain_hi;
		end
		res = run_rounds(pt, dec);
		if (cbc && dec) begin
			res.lo = res.lo ^ chain_lo; res.hi = res.hi ^ chain_hi;
			chain_lo = lo; chain_hi = hi;
		end else if (cbc) begin
			chain_lo = res.lo; chain_hi = res.hi;
		end
	endtask

	// one register write, mirrored in the model
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_KEY_A:    begin key_w[0] = val; keys_dirty = 1; end
			REG_KEY_B:    begin key_w[1] = val; keys_dirty = 1; end
			REG_KEY_C:    begin key_w[2] = val; keys_dirty = 1; end
			REG_KEY_D:    begin key_w[3] = val; keys_dirty = 1; end
			REG_KEY_SIZE: begin key_len = val[1:0]; keys_dirty = 1; end
			REG_MODE:     mode = val[1:0];
			REG_IV_LOW:   iv_lo = val;
			REG_IV_HIGH:  iv_hi = val;
			default:      ;
		endcase
	endtask

	// offer one request and hold it until accepted
	task automatic send_block(input vec_t v);
		blk128_t exp_blk;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_low <= v.lo;
		data_high <= v.hi;
		valid_bytes <= v.nbytes;
		first_block <= v.restart;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_block(v.lo, v.hi, v.nbytes, v.restart, exp_blk);
		if (v.typed) begin
			exp_blk.lo = v.want_lo;
			exp_blk.hi = v.want_hi;
		end
		pending_blocks.push_back(exp_blk);
	endtask

	// result side: compare against the oldest expected block
	always @(posedge clk) begin
		blk128_t exp_blk;
		if (arst_n && out_valid && out_ready) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected result %h_%h", $time, out_high, out_low);
				fail_count++;
			end else begin
				exp_blk = pending_blocks.pop_front();
				if (out_low !== exp_blk.lo) begin
					$display("%0t: out_low expected %h actual %h", $time, exp_blk.lo, out_low);
					fail_count++;
				end
				if (out_high !== exp_blk.hi) begin
					$display("%0t: out_high expected %h actual %h", $time, exp_blk.hi, out_high);
					fail_count++;
				end
			end
		end
	end

	// receiver back-pressure: random bursts and one long hold
	int  rx_idle = 0;
	bit  hold_done = 0;
	always @(posedge clk) begin
		logic nxt;
		nxt = 1'b1;
		if (hold_req && !hold_done) begin
			rx_idle = LONG_HOLD;
			hold_done = 1;
		end
		if (quiet) begin
			rx_idle = 0;
		end else if (rx_idle > 0) begin
			rx_idle--;
			nxt = 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_idle = $urandom_range(0, 8);
			nxt = 1'b0;
		end
		out_ready <= nxt;
	end

	// watchdog on cycles with no request moving on either side
	int stuck = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck = 0;
		end else if (arst_n) begin
			stuck++;
			if (stuck >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, stuck);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// directed requests under the reset configuration (ECB encrypt, zero 128-bit key)
	vec_t directed [0:11] = '{
		'{64'h0, 64'h0, 5'd16, 1'b0, 1, 64'h322C12F65C9F589F, 64'h5AC3E82A2FECBFB6},
		'{'1, '1, 5'd0, 1'b0, 1, 64'h322C12F65C9F589F, 64'h5AC3E82A2FECBFB6},
		'{'1, '1, 5'd31, 1'b1, 0, 64'h0, 64'h0},
		'{'1, '1, 5'd16, 1'b0, 0, 64'h0, 64'h0},
		'{'1, '1, 5'd17, 1'b0, 0, 64'h0, 64'h0},
		'{'1, '1, 5'd1, 1'b0, 0, 64'h0, 64'h0},
		'{'1, '1, 5'd7, 1'b1, 0, 64'h0, 64'h0},
		'{'1, '1, 5'd8, 1'b0, 0, 64'h0, 64'h0},
		'{'1, '1, 5'd9, 1'b0, 0, 64'h0, 64'h0},
		'{'1, '1, 5'd15, 1'b0, 0, 64'h0, 64'h0},
		'{64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd16, 1'b0, 0, 64'h0, 64'h0},
		'{64'h0, 64'h0, 5'd16, 1'b0, 1, 64'h322C12F65C9F589F, 64'h5AC3E82A2FECBFB6}
	};

	initial begin
		vec_t        v;
		logic [63:0] kv;
		int          r;
		for (int i = 0; i < 4; i++) key_w[i] = '0;
		key_len = '0; mode = '0; iv_lo = '0; iv_hi = '0;
		chain_lo = '0; chain_hi = '0;
		keys_dirty = 1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_block(directed[i]);

		for (int p = 1; p <= 13; p++) begin
			// settle: nothing outstanding before reconfiguring
			in_valid <= 1'b0;
			while (pending_blocks.size() != 0) @(posedge clk);
			repeat (4) @(posedge clk);
			for (int i = 0; i < 4; i++) begin
				kv = (p == 1) ? 64'h0 : (p == 2) ? '1 : {$urandom, $urandom};
				write_reg(cfg_reg_t'(REG_KEY_A + i), kv);
			end
			write_reg(REG_KEY_SIZE, 64'((p / 4) % 4));
			write_reg(REG_MODE, 64'(p % 4));
			write_reg(REG_IV_LOW, (p == 3) ? '1 : {$urandom, $urandom});
			write_reg(REG_IV_HIGH, (p == 3) ? '1 : {$urandom, $urandom});
			cfg_we <= 1'b0;
			if (p == 2) hold_req = 1;
			if (p == 13) quiet = 1;
			for (int n = 0; n < 135; n++) begin
				v.lo = {$urandom, $urandom};
				v.hi = {$urandom, $urandom};
				r = $urandom_range(0, 9);
				v.nbytes = (r < 7) ? 5'd16 : 5'($urandom_range(0, 31));
				// chains mostly restart at the head of a run, now and then mid-stream
				v.restart = (n == 0) || ($urandom_range(0, 11) == 0);
				v.typed = 0;
				v.want_lo = '0;
				v.want_hi = '0;
				send_block(v);
			end
		end
		in_valid <= 1'b0;

		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
